// ===== src/bltc_pkg.sv =====
`default_nettype none

package bltc_pkg;

  // Keyword table: entries 0 to 11 carry their own token code, the last one is REM.
  localparam int unsigned KwCount = 13;
  localparam int unsigned KwRem   = 12;
  localparam int unsigned KwSlots = 8;

  typedef logic [7:0] char_t;
  typedef logic [4:0] kind_t;

  localparam kind_t KIND_INT    = 5'd12;
  localparam kind_t KIND_ID     = 5'd13;
  localparam kind_t KIND_ERROR  = 5'd14;
  localparam kind_t KIND_REMARK = 5'd15;
  localparam kind_t KIND_NONE   = 5'd16;

  localparam char_t CHAR_SPACE   = 8'h20;
  localparam char_t CHAR_NEWLINE = 8'h0A;
  localparam char_t CHAR_PLUS    = "+";
  localparam char_t CHAR_MINUS   = "-";
  localparam char_t CHAR_UNDER   = "_";
  localparam char_t CHAR_NUL     = 8'h00;

  localparam logic [35:0] INT_POS_MAX = 36'h0_7FFF_FFFF;
  localparam logic [35:0] INT_NEG_MAX = 36'h0_8000_0000;

  localparam char_t KW_TEXT [KwCount][KwSlots] = '{
    '{"I", "F", CHAR_NUL, CHAR_NUL, CHAR_NUL, CHAR_NUL, CHAR_NUL, CHAR_NUL},
    '{"T", "H", "E", "N", CHAR_NUL, CHAR_NUL, CHAR_NUL, CHAR_NUL},
    '{"L", "E", "T", CHAR_NUL, CHAR_NUL, CHAR_NUL, CHAR_NUL, CHAR_NUL},
    '{"G", "O", "T", "O", CHAR_NUL, CHAR_NUL, CHAR_NUL, CHAR_NUL},
    '{"E", "N", "D", CHAR_NUL, CHAR_NUL, CHAR_NUL, CHAR_NUL, CHAR_NUL},
    '{"P", "R", "I", "N", "T", CHAR_NUL, CHAR_NUL, CHAR_NUL},
    '{"=", CHAR_NUL, CHAR_NUL, CHAR_NUL, CHAR_NUL, CHAR_NUL, CHAR_NUL, CHAR_NUL},
    '{">", CHAR_NUL, CHAR_NUL, CHAR_NUL, CHAR_NUL, CHAR_NUL, CHAR_NUL, CHAR_NUL},
    '{"<", CHAR_NUL, CHAR_NUL, CHAR_NUL, CHAR_NUL, CHAR_NUL, CHAR_NUL, CHAR_NUL},
    '{"+", CHAR_NUL, CHAR_NUL, CHAR_NUL, CHAR_NUL, CHAR_NUL, CHAR_NUL, CHAR_NUL},
    '{"-", CHAR_NUL, CHAR_NUL, CHAR_NUL, CHAR_NUL, CHAR_NUL, CHAR_NUL, CHAR_NUL},
    '{"I", "N", "P", "U", "T", CHAR_NUL, CHAR_NUL, CHAR_NUL},
    '{"R", "E", "M", CHAR_NUL, CHAR_NUL, CHAR_NUL, CHAR_NUL, CHAR_NUL}
  };

  localparam logic [2:0] KW_LEN [KwCount] = '{
    3'd2, 3'd4, 3'd3, 3'd4, 3'd3, 3'd5, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd5, 3'd3
  };

  typedef struct packed {
    char_t char_byte;
    logic  line_last;
  } in_t;

  typedef struct packed {
    kind_t token_kind;
    logic  line_end;
  } out_t;

endpackage

`default_nettype wire

// ===== src/bltc_lex.sv =====
`default_nettype none

module bltc_lex (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         fire_i,
  input  wire bltc_pkg::in_t item_i,
  output logic              res_valid_o,
  output bltc_pkg::out_t    res_o
);

  logic [bltc_pkg::KwCount-1:0] mask_q, mask_d;
  logic [2:0]  len_q, len_d;
  logic        int_ok_q, int_ok_d;
  logic        sign_q, sign_d;
  logic        neg_q, neg_d;
  logic [31:0] mag_q, mag_d;
  logic        id_ok_q, id_ok_d;
  logic        nl_only_q, nl_only_d;
  logic        swallow_q, swallow_d;

  // Word state with the current byte folded in.
  logic [bltc_pkg::KwCount-1:0] mask_a;
  logic [2:0]  len_a;
  logic        int_ok_a, sign_a, neg_a, id_ok_a, nl_only_a;
  logic [31:0] mag_a;

  bltc_pkg::char_t c;
  logic        is_space, is_letter, is_digit, is_sign;
  logic [35:0] mag_x10, lim;
  logic        kw_hit, skip, word_end;
  bltc_pkg::kind_t kind;

  assign c         = item_i.char_byte;
  assign is_space  = (c == bltc_pkg::CHAR_SPACE);
  assign is_letter = (c inside {["A":"Z"], ["a":"z"]});
  assign is_digit  = (c inside {["0":"9"]});
  assign is_sign   = (c == bltc_pkg::CHAR_PLUS) || (c == bltc_pkg::CHAR_MINUS);

  // Decimal accumulate as shift and add, checked against the signed limit.
  assign mag_x10 = ({4'd0, mag_q} << 3) + ({4'd0, mag_q} << 1)
                 + {32'd0, c[3:0] - 4'd0};
  assign lim     = neg_q ? bltc_pkg::INT_NEG_MAX : bltc_pkg::INT_POS_MAX;

  // Fold one byte into the word state; a space leaves the word as it is.
  always_comb begin
    mask_a    = mask_q;
    len_a     = len_q;
    int_ok_a  = int_ok_q;
    sign_a    = sign_q;
    neg_a     = neg_q;
    mag_a     = mag_q;
    id_ok_a   = id_ok_q;
    nl_only_a = nl_only_q;
    if (!is_space) begin
      for (int k = 0; k < bltc_pkg::KwCount; k++) begin
        mask_a[k] = mask_q[k] && (len_q < bltc_pkg::KW_LEN[k])
                    && (bltc_pkg::KW_TEXT[k][len_q] == c);
      end
      if (c != bltc_pkg::CHAR_NEWLINE) begin
        nl_only_a = 1'b0;
      end
      if ((len_q == 3'd0) && is_sign) begin
        sign_a = 1'b1;
        neg_a  = (c == bltc_pkg::CHAR_MINUS);
      end else if (is_digit) begin
        if (int_ok_q) begin
          if (mag_x10 > lim) begin
            int_ok_a = 1'b0;
          end else begin
            mag_a = mag_x10[31:0];
          end
        end
      end else begin
        int_ok_a = 1'b0;
      end
      if (len_q == 3'd0) begin
        if (!is_letter) begin
          id_ok_a = 1'b0;
        end
      end else if (!(is_letter || is_digit || (c == bltc_pkg::CHAR_UNDER))) begin
        id_ok_a = 1'b0;
      end
      len_a = (len_q == 3'd7) ? 3'd7 : len_q + 3'd1;
    end
  end

  // Classify the word as it stands after this byte.
  always_comb begin
    kw_hit = 1'b0;
    kind   = bltc_pkg::KIND_ERROR;
    skip   = 1'b0;
    for (int k = 0; k < bltc_pkg::KwCount; k++) begin
      if (!kw_hit && mask_a[k] && (bltc_pkg::KW_LEN[k] == len_a)) begin
        kw_hit = 1'b1;
        kind   = (k == bltc_pkg::KwRem) ? bltc_pkg::KIND_REMARK : 5'(k);
      end
    end
    if (len_a == 3'd0) begin
      skip = 1'b1;
    end else if (!kw_hit) begin
      if (nl_only_a && (len_a == 3'd1)) begin
        skip = 1'b1;
      end else if (int_ok_a && (len_a > {2'd0, sign_a})) begin
        kind = bltc_pkg::KIND_INT;
      end else if (id_ok_a) begin
        kind = bltc_pkg::KIND_ID;
      end
    end
  end

  assign word_end = is_space || item_i.line_last;

  // Next state and the result of this item.
  always_comb begin
    mask_d      = mask_q;
    len_d       = len_q;
    int_ok_d    = int_ok_q;
    sign_d      = sign_q;
    neg_d       = neg_q;
    mag_d       = mag_q;
    id_ok_d     = id_ok_q;
    nl_only_d   = nl_only_q;
    swallow_d   = swallow_q;
    res_valid_o = 1'b0;
    res_o       = '{token_kind: bltc_pkg::KIND_NONE, line_end: 1'b0};
    if (fire_i) begin
      if (swallow_q || word_end) begin
        // The word closes: the state returns to the start of a word.
        mask_d    = '1;
        len_d     = 3'd0;
        int_ok_d  = 1'b1;
        sign_d    = 1'b0;
        neg_d     = 1'b0;
        mag_d     = 32'd0;
        id_ok_d   = 1'b1;
        nl_only_d = 1'b1;
      end
      if (swallow_q) begin
        // Rest of a remark line: only its final byte gives a result.
        if (item_i.line_last) begin
          swallow_d   = 1'b0;
          res_valid_o = 1'b1;
          res_o       = '{token_kind: bltc_pkg::KIND_REMARK, line_end: 1'b1};
        end else begin
          mask_d    = mask_q;
          len_d     = len_q;
          int_ok_d  = int_ok_q;
          sign_d    = sign_q;
          neg_d     = neg_q;
          mag_d     = mag_q;
          id_ok_d   = id_ok_q;
          nl_only_d = nl_only_q;
        end
      end else if (!word_end) begin
        mask_d    = mask_a;
        len_d     = len_a;
        int_ok_d  = int_ok_a;
        sign_d    = sign_a;
        neg_d     = neg_a;
        mag_d     = mag_a;
        id_ok_d   = id_ok_a;
        nl_only_d = nl_only_a;
      end else if (item_i.line_last) begin
        res_valid_o = 1'b1;
        res_o = '{token_kind: skip ? bltc_pkg::KIND_NONE : kind, line_end: 1'b1};
      end else if (!skip && (kind == bltc_pkg::KIND_REMARK)) begin
        swallow_d = 1'b1;
      end else if (!skip) begin
        res_valid_o = 1'b1;
        res_o       = '{token_kind: kind, line_end: 1'b0};
      end
    end
  end

  // Line and word state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q    <= '1;
      len_q     <= 3'd0;
      int_ok_q  <= 1'b1;
      sign_q    <= 1'b0;
      neg_q     <= 1'b0;
      mag_q     <= 32'd0;
      id_ok_q   <= 1'b1;
      nl_only_q <= 1'b1;
      swallow_q <= 1'b0;
    end else begin
      mask_q    <= mask_d;
      len_q     <= len_d;
      int_ok_q  <= int_ok_d;
      sign_q    <= sign_d;
      neg_q     <= neg_d;
      mag_q     <= mag_d;
      id_ok_q   <= id_ok_d;
      nl_only_q <= nl_only_d;
      swallow_q <= swallow_d;
    end
  end

endmodule

`default_nettype wire

// ===== src/basic_line_token_classifier_core.sv =====
// Channel | Direction | Payload         | Handshake
// in      | input     | bltc_pkg::in_t  | in_valid_i / in_stall_o
// out     | output    | bltc_pkg::out_t | out_valid_o / out_stall_i
//
// One byte is taken every cycle while in_stall_o is low; a byte is held in the
// input register, then the classifier writes any result into the result register.
// Reset clears both registers' valid flags and puts the line state at the start of a line.
// A stalled result holds the input register; in_stall_o rises in the same
// cycle only when both registers are full and the output is stalled.
`default_nettype none

module basic_line_token_classifier_core (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_stall_o,
  input  wire bltc_pkg::in_t in_item_i,
  output logic               out_valid_o,
  input  wire logic          out_stall_i,
  output bltc_pkg::out_t     out_item_o
);

  logic           in_vld_q, in_vld_d;
  bltc_pkg::in_t  in_q;
  logic           out_vld_q, out_vld_d;
  bltc_pkg::out_t out_q;
  logic           out_free, fire, in_take, res_valid;
  bltc_pkg::out_t res;

  // The result register can take a new item when empty or being drained.
  assign out_free   = !out_vld_q || !out_stall_i;
  assign fire       = in_vld_q && out_free;
  assign in_stall_o = in_vld_q && !out_free;
  assign in_take    = in_valid_i && !in_stall_o;

  bltc_lex u_lex (
    .clk_i,
    .rst_ni,
    .fire_i      (fire),
    .item_i      (in_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  always_comb begin
    in_vld_d = in_vld_q;
    if (in_take) begin
      in_vld_d = 1'b1;
    end else if (fire) begin
      in_vld_d = 1'b0;
    end
    out_vld_d = out_vld_q;
    if (fire) begin
      out_vld_d = res_valid;
    end else if (!out_stall_i) begin
      out_vld_d = 1'b0;
    end
  end

  // Valid flags.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_q <= in_item_i;
    end
    if (fire && res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_item_o  = out_q;

endmodule

`default_nettype wire

// ===== src/bltc_checker.sv =====
`default_nettype none

module bltc_checker (
  input wire logic           clk_i,
  input wire logic           rst_ni,
  input wire logic           in_valid_i,
  input wire logic           in_stall_o,
  input wire bltc_pkg::in_t  in_item_i,
  input wire logic           out_valid_o,
  input wire logic           out_stall_i,
  input wire bltc_pkg::out_t out_item_o
);

  // A held result stays in place until it is taken.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_item_o))
    else $error("result item changed while stalled");

  // A stalled input item is offered again unchanged.
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=> in_valid_i && $stable(in_item_i))
    else $error("input item changed while stalled");

  // The input side only backs up behind a stalled, full output.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without a stalled output");

  // Token codes stay within the defined set.
  a_kind_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_item_o.token_kind <= bltc_pkg::KIND_NONE)
    else $error("token code out of range");

  // Only the end of a line can carry a remark or no token.
  a_line_end_kinds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && ((out_item_o.token_kind == bltc_pkg::KIND_NONE)
                    || (out_item_o.token_kind == bltc_pkg::KIND_REMARK))
    |-> out_item_o.line_end)
    else $error("remark or empty token before the line's end");

endmodule

bind basic_line_token_classifier_core bltc_checker u_bltc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_item_i   (in_item_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_item_o  (out_item_o)
);

`default_nettype wire
